// ----- design/tracker_follow_detector_core_assert.svh -----
// Assertion helpers for the follow detector core.
`ifndef TRACKER_FOLLOW_DETECTOR_CORE_ASSERT_SVH
`define TRACKER_FOLLOW_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define TFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define TFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/tfd_pkg.sv -----
package tfd_pkg;

    localparam logic [1:0] ACT_ADV   = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_DWELL = 2'd2;

    localparam logic [1:0] CFG_GAP    = 2'd0;
    localparam logic [1:0] CFG_FOLLOW = 2'd1;
    localparam logic [1:0] CFG_LIVE   = 2'd2;

    localparam logic [31:0] GAP_RESET    = 32'd90000;
    localparam logic [31:0] FOLLOW_RESET = 32'd300000;
    localparam logic [31:0] LIVE_RESET   = 32'd4000;

    localparam logic signed [7:0] NO_LEVEL = -8'sd127;

    typedef struct packed {
        logic start;
        logic step;
        logic update;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
    } t_status;

endpackage

// ----- design/tfd_ctrl.sv -----
module tfd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  tfd_pkg::t_status i_status,
    output tfd_pkg::t_cmd    o_cmd
);
    import tfd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE, S_REPORT} t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.start  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step   = (r_state == S_SCAN);
        o_cmd.update = (r_state == S_UPDATE);
        o_cmd.report = (r_state == S_REPORT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result, else drop the one the consumer just took
            if (o_cmd.report)      r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (i_status.scan_last) r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- design/tfd_dp.sv -----
module tfd_dp #(
    parameter int NUM_CLASSES   = 5,
    parameter int TABLE_ENTRIES = 24,
    parameter int HISTORY_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tfd_pkg::t_cmd      i_cmd,
    output tfd_pkg::t_status   o_status,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_now_ms,
    input  logic [2:0]         i_class_kind,
    input  logic [47:0]        i_mac_address,
    input  logic signed [7:0]  i_signal_dbm,
    input  logic               i_lost_mode,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_class_active,
    output logic               o_class_follow,
    output logic               o_class_separated,
    output logic signed [7:0]  o_smoothed_dbm,
    output logic [2:0]         o_address_count,
    output logic [31:0]        o_dwell_ms,
    output logic signed [7:0]  o_best_live_dbm,
    output logic               o_seen_edge,
    output logic               o_follow_edge
);
    import tfd_pkg::*;

    localparam int KW       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int TW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int HW       = $clog2(HISTORY_DEPTH);
    localparam int FW       = $clog2(HISTORY_DEPTH + 1);
    localparam int SCAN_LEN = (TABLE_ENTRIES > HISTORY_DEPTH) ? TABLE_ENTRIES : HISTORY_DEPTH;
    localparam int SW       = $clog2(SCAN_LEN);

    // configuration
    logic [31:0] r_gap, r_follow, r_live;

    // captured item
    logic [1:0]        r_action;
    logic [31:0]       r_now;
    logic [2:0]        r_class;
    logic [47:0]       r_mac;
    logic signed [7:0] r_dbm;
    logic              r_lost;

    // per-class state
    logic [31:0]       r_dwell [NUM_CLASSES];
    logic [31:0]       r_last  [NUM_CLASSES];
    logic signed [7:0] r_avg   [NUM_CLASSES];
    logic [15:0]       r_hits  [NUM_CLASSES];
    logic              r_sep   [NUM_CLASSES];
    logic [FW-1:0]     r_fill  [NUM_CLASSES];
    logic [HW-1:0]     r_head  [NUM_CLASSES];
    logic              r_seen_rep [NUM_CLASSES];
    logic              r_fol_rep  [NUM_CLASSES];
    logic [47:0]       r_hist  [NUM_CLASSES][HISTORY_DEPTH];

    // address table
    logic              r_ev [TABLE_ENTRIES];
    logic [47:0]       r_ea [TABLE_ENTRIES];
    logic [2:0]        r_ec [TABLE_ENTRIES];
    logic signed [7:0] r_ed [TABLE_ENTRIES];
    logic [31:0]       r_et [TABLE_ENTRIES];

    // scan results
    logic [SW-1:0]     r_cnt;
    logic              r_hmatch;
    logic              r_tm, r_te, r_to_have;
    logic [TW-1:0]     r_tm_idx, r_te_idx, r_to_idx;
    logic [31:0]       r_to_age;
    logic signed [7:0] r_best;

    logic          in_range;
    logic [KW-1:0] ks;
    logic [TW-1:0] tidx;
    logic [HW-1:0] hidx;
    logic          t_in, h_in;
    logic [31:0]   e_age;

    assign in_range = (32'(r_class) < NUM_CLASSES);
    assign ks       = in_range ? KW'(r_class) : '0;
    assign tidx     = r_cnt[TW-1:0];
    assign hidx     = r_cnt[HW-1:0];
    assign t_in     = (32'(r_cnt) < TABLE_ENTRIES);
    assign h_in     = (32'(r_cnt) < HISTORY_DEPTH) && (32'(r_cnt) < 32'(r_fill[ks]));
    assign e_age    = r_now - r_et[tidx];
    assign o_status.scan_last = (r_cnt == SW'(SCAN_LEN - 1));

    // advertisement update terms
    logic              restart;
    logic              add_hist;
    logic [FW-1:0]     fill0;
    logic [HW-1:0]     head0;
    logic [FW-1:0]     n_fill;
    logic [HW-1:0]     n_head;
    logic [TW-1:0]     slot;
    logic signed [10:0] a_ext, d_ext, s0, s1;
    logic signed [7:0]  avg_new;

    always_comb begin
        restart  = (r_hits[ks] == 16'd0) || ((r_now - r_last[ks]) > r_gap);
        fill0    = restart ? '0 : r_fill[ks];
        head0    = restart ? '0 : r_head[ks];
        add_hist = !(r_hmatch && !restart);
        n_fill   = fill0;
        n_head   = head0;
        if (add_hist) begin
            if (32'(fill0) < HISTORY_DEPTH) n_fill = fill0 + 1'b1;
            else n_head = (head0 == HW'(HISTORY_DEPTH - 1)) ? '0 : head0 + 1'b1;
        end
        slot    = r_tm ? r_tm_idx : (r_te ? r_te_idx : r_to_idx);
        a_ext   = 11'(r_avg[ks]);
        d_ext   = 11'(r_dbm);
        s0      = (a_ext <<< 1) + a_ext + d_ext;
        s1      = s0 + (s0[10] ? 11'sd3 : 11'sd0);
        avg_new = 8'(s1 >>> 2);
    end

    // report terms
    logic act, fol, pair_class;
    always_comb begin
        pair_class = (r_class == 3'd0) || (r_class == 3'd1);
        act = (r_hits[ks] != 16'd0) && ((r_now - r_last[ks]) < r_gap);
        fol = act && ((r_now - r_dwell[ks]) >= r_follow) &&
              (!pair_class || (32'(r_fill[ks]) >= 2) || r_sep[ks]);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap    <= GAP_RESET;
            r_follow <= FOLLOW_RESET;
            r_live   <= LIVE_RESET;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_dwell[c]    <= '0;
                r_last[c]     <= '0;
                r_avg[c]      <= '0;
                r_hits[c]     <= '0;
                r_sep[c]      <= 1'b0;
                r_fill[c]     <= '0;
                r_head[c]     <= '0;
                r_seen_rep[c] <= 1'b0;
                r_fol_rep[c]  <= 1'b0;
            end
            for (int e = 0; e < TABLE_ENTRIES; e++) r_ev[e] <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GAP:    r_gap    <= i_cfg_data;
                    CFG_FOLLOW: r_follow <= i_cfg_data;
                    CFG_LIVE:   r_live   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.start) r_cnt <= '0;
            else if (i_cmd.step && !o_status.scan_last) r_cnt <= r_cnt + 1'b1;

            if (i_cmd.update) begin
                if (r_action == ACT_ADV && in_range) begin
                    if (restart) begin
                        r_dwell[ks] <= r_now;
                        r_sep[ks]   <= r_lost;
                    end else if (r_lost) begin
                        r_sep[ks] <= 1'b1;
                    end
                    r_last[ks] <= r_now;
                    r_avg[ks]  <= (r_hits[ks] != 16'd0) ? avg_new : r_dbm;
                    if (r_hits[ks] != 16'hFFFF) r_hits[ks] <= r_hits[ks] + 16'd1;
                    r_fill[ks] <= n_fill;
                    r_head[ks] <= n_head;
                    r_ev[slot] <= 1'b1;
                end else if (r_action == ACT_DWELL) begin
                    for (int c = 0; c < NUM_CLASSES; c++)
                        if (r_hits[c] != 16'd0) r_dwell[c] <= r_now;
                end
            end

            if (i_cmd.report && r_action == ACT_QUERY && in_range) begin
                if (act && !r_seen_rep[ks]) r_seen_rep[ks] <= 1'b1;
                else if (!act)              r_seen_rep[ks] <= 1'b0;
                if (fol && !r_fol_rep[ks])  r_fol_rep[ks]  <= 1'b1;
                else if (!fol)              r_fol_rep[ks]  <= 1'b0;
            end
        end
    end

    // payload storage and scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_action  <= i_action;
            r_now     <= i_now_ms;
            r_class   <= i_class_kind;
            r_mac     <= i_mac_address;
            r_dbm     <= i_signal_dbm;
            r_lost    <= i_lost_mode;
            r_hmatch  <= 1'b0;
            r_tm      <= 1'b0;
            r_te      <= 1'b0;
            r_to_have <= 1'b0;
            r_tm_idx  <= '0;
            r_te_idx  <= '0;
            r_to_idx  <= '0;
            r_to_age  <= '0;
            r_best    <= NO_LEVEL;
        end
        if (i_cmd.step) begin
            if (h_in && r_hist[ks][hidx] == r_mac) r_hmatch <= 1'b1;
            if (t_in) begin
                if (r_ev[tidx]) begin
                    if (!r_tm && r_ea[tidx] == r_mac) begin
                        r_tm     <= 1'b1;
                        r_tm_idx <= tidx;
                    end
                    if (!r_to_have || e_age > r_to_age) begin
                        r_to_have <= 1'b1;
                        r_to_idx  <= tidx;
                        r_to_age  <= e_age;
                    end
                    if (r_ec[tidx] == r_class && e_age < r_live && r_ed[tidx] > r_best)
                        r_best <= r_ed[tidx];
                end else if (!r_te) begin
                    r_te     <= 1'b1;
                    r_te_idx <= tidx;
                end
            end
        end
        if (i_cmd.update && r_action == ACT_ADV && in_range) begin
            if (add_hist) begin
                if (32'(fill0) < HISTORY_DEPTH) r_hist[ks][HW'(fill0)] <= r_mac;
                else                             r_hist[ks][head0]      <= r_mac;
            end
            r_ea[slot] <= r_mac;
            r_ec[slot] <= r_class;
            r_ed[slot] <= r_dbm;
            r_et[slot] <= r_now;
        end
        if (i_cmd.report) begin
            o_class_active    <= in_range && act;
            o_class_follow    <= in_range && fol;
            o_class_separated <= in_range && r_sep[ks];
            o_smoothed_dbm    <= in_range ? r_avg[ks] : 8'sd0;
            o_address_count   <= !in_range ? 3'd0 :
                                 (32'(r_fill[ks]) > 7) ? 3'd7 : 3'(r_fill[ks]);
            o_dwell_ms        <= in_range ? (r_now - r_dwell[ks]) : 32'd0;
            o_best_live_dbm   <= (in_range && r_action == ACT_QUERY) ? r_best : NO_LEVEL;
            o_seen_edge       <= in_range && r_action == ACT_QUERY && act && !r_seen_rep[ks];
            o_follow_edge     <= in_range && r_action == ACT_QUERY && fol && !r_fol_rep[ks];
        end
    end
endmodule

// ----- design/tracker_follow_detector_core.sv -----
// Tracker follow detector. Each transaction on the input channel is an
// advertisement, a class status query or a dwell reset, stamped with a
// wrapping millisecond time, and yields exactly one result transaction that
// describes the item's class after the item is applied. One item is in work
// at a time: the controller walks the address table and the class history
// one entry per cycle, then applies the item and loads the result into the
// output register, which waits while the previous result still sits
// unaccepted there; only then is the next item taken.
// The configuration port is always ready; write it only while the block is
// idle. Class codes at or above NUM_CLASSES return an all-zero status with
// a best level of -127 and change nothing, except that a dwell reset still
// restarts the dwell of every class that has been seen.
`include "tracker_follow_detector_core_assert.svh"

module tracker_follow_detector_core #(
    parameter int NUM_CLASSES   = 5,
    parameter int TABLE_ENTRIES = 24,
    parameter int HISTORY_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_action,
    input  logic [31:0]       i_now_ms,
    input  logic [2:0]        i_class_kind,
    input  logic [47:0]       i_mac_address,
    input  logic signed [7:0] i_signal_dbm,
    input  logic              i_lost_mode,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_class_active,
    output logic              o_class_follow,
    output logic              o_class_separated,
    output logic signed [7:0] o_smoothed_dbm,
    output logic [2:0]        o_address_count,
    output logic [31:0]       o_dwell_ms,
    output logic signed [7:0] o_best_live_dbm,
    output logic              o_seen_edge,
    output logic              o_follow_edge,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import tfd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Registers are plain flops: take a write on any cycle.
    assign o_cfg_ready = 1'b1;

    tfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tfd_dp #(
        .NUM_CLASSES   (NUM_CLASSES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_action          (i_action),
        .i_now_ms          (i_now_ms),
        .i_class_kind      (i_class_kind),
        .i_mac_address     (i_mac_address),
        .i_signal_dbm      (i_signal_dbm),
        .i_lost_mode       (i_lost_mode),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_class_active    (o_class_active),
        .o_class_follow    (o_class_follow),
        .o_class_separated (o_class_separated),
        .o_smoothed_dbm    (o_smoothed_dbm),
        .o_address_count   (o_address_count),
        .o_dwell_ms        (o_dwell_ms),
        .o_best_live_dbm   (o_best_live_dbm),
        .o_seen_edge       (o_seen_edge),
        .o_follow_edge     (o_follow_edge)
    );

    // A new result never overwrites one the consumer has not taken.
    `TFD_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.report, !(o_out_valid && i_out_stall))
    // Once an item is taken, hold off the next one.
    `TFD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, cmd.start, o_in_stall)
    // Follow implies active.
    `TFD_ASSERT_NOW(a_follow_needs_active, i_clk, i_rst_n, o_out_valid && o_class_follow,
                    o_class_active)
    // A seen edge only on an active class.
    `TFD_ASSERT_NOW(a_seen_edge_active, i_clk, i_rst_n, o_out_valid && o_seen_edge,
                    o_class_active)
endmodule
